>>> rtl/sled_pkg.sv
// Package for the serial line editor with echo.
// Holds character codes, command classes and the result burst type.
// No dependencies.
package sled_pkg;

   localparam int MAX_WORDS_DEF      = 10;
   localparam int MAX_WORD_CHARS_DEF = 100;
   localparam int BURST_MAX          = 4;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_S     = 8'h73;

   typedef enum logic [1:0] {
      CLS_EMPTY = 2'd0,
      CLS_CD    = 2'd1,
      CLS_LS    = 2'd2,
      CLS_BAD   = 2'd3
   } cls_type;

   // One item's worth of transmit bytes.
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [1:0]                cnt_m1;
      logic                      done;
      logic [3:0]                wc;
      cls_type                   cls;
   } burst_type;

endpackage

>>> rtl/sled_emit.sv
// Result emitter: holds one burst of up to four bytes and sends them in order.
// Depends on sled_pkg.
module sled_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sled_pkg::burst_type burst,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last,
   output logic                rsp_line_done,
   output logic [3:0]          rsp_word_count,
   output logic [1:0]          rsp_command_class
);

   logic                vld_ff, vld_in;
   logic [1:0]          idx_ff, idx_in;
   sled_pkg::burst_type bst_ff;
   logic                take;

   assign rsp_valid         = vld_ff;
   assign rsp_last          = (idx_ff == bst_ff.cnt_m1);
   assign rsp_out_byte      = bst_ff.bytes[idx_ff];
   assign rsp_line_done     = rsp_last & bst_ff.done;
   assign rsp_word_count    = rsp_line_done ? bst_ff.wc : 4'd0;
   assign rsp_command_class = rsp_line_done ? bst_ff.cls : sled_pkg::CLS_EMPTY;

   assign take = vld_ff & ~rsp_stall;
   assign free = ~vld_ff | (take & rsp_last);

   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (take) begin
         idx_in = idx_ff + 2'd1;
         if (rsp_last) begin
            vld_in = 1'b0;
         end
      end
      if (load && free) begin
         vld_in = 1'b1;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         bst_ff <= burst;
      end
   end

endmodule

>>> rtl/serial_line_editor_echo_unit.sv
// Serial line editor with echo, top level.
// Depends on sled_pkg and sled_emit.
//
// Input channel (req_): one item is a received byte (req_kind = 0) or a start
// event (req_kind = 1) that clears the line and prints the prompt "> ".
// Result channel (rsp_): zero to four transmit bytes per item, rsp_last on the
// final one. A carriage return ends with rsp_line_done set, the index of the
// final word in rsp_word_count and the command class in rsp_command_class.
// The first result of an item passes the execute register (hold_*) and then
// the emitter's burst register. A backspace that steps back into the
// previous word waits longer in execute, since it reads that word's length
// from the word length memory, which has a registered read port.
// Throughput: one item per cycle into execute while req_stall is low; the
// result port sends one byte per cycle while rsp_stall is low, and an item
// leaves execute only once the emitter is free to take its burst.
// Reset clears the line: word and character indices zero, prompt not sent.
// When the receiver stalls, the current burst holds; one item in execute
// waits, then req_stall rises.
module serial_line_editor_echo_unit #(
   parameter int MAX_WORDS      = sled_pkg::MAX_WORDS_DEF,
   parameter int MAX_WORD_CHARS = sled_pkg::MAX_WORD_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_line_done,
   output logic [3:0] rsp_word_count,
   output logic [1:0] rsp_command_class
);

   localparam int WI_W = $clog2(MAX_WORDS);
   localparam logic [WI_W-1:0] WI_LAST = WI_W'(MAX_WORDS - 1);
   localparam logic [6:0]      CI_FULL = 7'(MAX_WORD_CHARS);

   logic       hold_vld_ff, hold_vld_in;
   logic       hold_kind_ff;
   logic [7:0] hold_byte_ff;
   logic       rdwait_ff, rdwait_in;

   logic [WI_W-1:0] wi_ff, wi_in;
   logic [6:0]      ci_ff, ci_in;
   logic [6:0]      w0len_ff, w0len_in;
   logic [1:0][7:0] head_ff, head_in;

   logic [6:0] len_mem [MAX_WORDS];
   logic [6:0] rd_data_ff;
   logic       rd_en, wr_en;

   logic                accept, exe_done, need_rd, emit_free, emit_load;
   logic [6:0]          len0;
   sled_pkg::burst_type burst;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = hold_vld_ff & ~exe_done;

   assign need_rd = ~hold_kind_ff & (wi_ff != '0) & (ci_ff == 7'd0)
                    & ((hold_byte_ff == sled_pkg::CH_BS) | (hold_byte_ff == sled_pkg::CH_DEL));
   assign rd_en    = hold_vld_ff & need_rd & ~rdwait_ff;
   assign exe_done = hold_vld_ff & ~(need_rd & ~rdwait_ff) & emit_free;
   assign len0     = (wi_ff == '0) ? ci_ff : w0len_ff;

   always_comb begin
      wi_in     = wi_ff;
      ci_in     = ci_ff;
      w0len_in  = w0len_ff;
      head_in   = head_ff;
      wr_en     = 1'b0;
      emit_load = 1'b0;
      burst     = '0;
      if (exe_done) begin
         if (hold_kind_ff) begin
            wi_in = '0;
            ci_in = 7'd0;
            w0len_in = 7'd0;
            head_in = '0;
            emit_load = 1'b1;
            burst.bytes[0] = sled_pkg::CH_GT;
            burst.bytes[1] = sled_pkg::CH_SPACE;
            burst.cnt_m1 = 2'd1;
         end else begin
            priority if (hold_byte_ff == sled_pkg::CH_CR) begin
               emit_load = 1'b1;
               burst.bytes[0] = sled_pkg::CH_CR;
               burst.bytes[1] = sled_pkg::CH_LF;
               burst.bytes[2] = sled_pkg::CH_GT;
               burst.bytes[3] = sled_pkg::CH_SPACE;
               burst.cnt_m1 = 2'd3;
               burst.done = 1'b1;
               burst.wc = 4'(wi_ff);
               if (len0 == 7'd0) begin
                  burst.cls = sled_pkg::CLS_EMPTY;
               end else if (len0 == 7'd2 && head_ff[0] == sled_pkg::CH_C
                            && head_ff[1] == sled_pkg::CH_D) begin
                  burst.cls = sled_pkg::CLS_CD;
               end else if (len0 == 7'd2 && head_ff[0] == sled_pkg::CH_L
                            && head_ff[1] == sled_pkg::CH_S) begin
                  burst.cls = sled_pkg::CLS_LS;
               end else begin
                  burst.cls = sled_pkg::CLS_BAD;
               end
               wi_in = '0;
               ci_in = 7'd0;
               w0len_in = 7'd0;
               head_in = '0;
            end else if (hold_byte_ff == sled_pkg::CH_SPACE) begin
               if (wi_ff != WI_LAST) begin
                  wr_en = 1'b1;
                  if (wi_ff == '0) begin
                     w0len_in = ci_ff;
                  end
                  wi_in = wi_ff + 1'b1;
                  ci_in = 7'd0;
                  emit_load = 1'b1;
                  burst.bytes[0] = sled_pkg::CH_SPACE;
               end
            end else if (hold_byte_ff == sled_pkg::CH_BS || hold_byte_ff == sled_pkg::CH_DEL) begin
               if (wi_ff != '0 || ci_ff != 7'd0) begin
                  if (ci_ff == 7'd0) begin
                     wi_in = wi_ff - 1'b1;
                     ci_in = rd_data_ff;
                  end else begin
                     ci_in = ci_ff - 7'd1;
                  end
                  emit_load = 1'b1;
                  burst.bytes[0] = sled_pkg::CH_BS;
                  burst.bytes[1] = sled_pkg::CH_DEL;
                  burst.bytes[2] = sled_pkg::CH_BS;
                  burst.cnt_m1 = 2'd2;
               end
            end else if (hold_byte_ff == sled_pkg::CH_ESC) begin
               emit_load = 1'b0;
            end else begin
               if (ci_ff < CI_FULL) begin
                  if (wi_ff == '0 && ci_ff < 7'd2) begin
                     head_in[ci_ff[0]] = hold_byte_ff;
                  end
                  ci_in = ci_ff + 7'd1;
                  emit_load = 1'b1;
                  burst.bytes[0] = hold_byte_ff;
               end
            end
         end
      end
   end

   always_comb begin
      hold_vld_in = hold_vld_ff;
      rdwait_in   = rdwait_ff;
      if (rd_en) begin
         rdwait_in = 1'b1;
      end
      if (exe_done) begin
         hold_vld_in = 1'b0;
         rdwait_in   = 1'b0;
      end
      if (accept) begin
         hold_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         rdwait_ff   <= 1'b0;
         wi_ff       <= '0;
         ci_ff       <= 7'd0;
         w0len_ff    <= 7'd0;
         head_ff     <= '0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         rdwait_ff   <= rdwait_in;
         wi_ff       <= wi_in;
         ci_ff       <= ci_in;
         w0len_ff    <= w0len_in;
         head_ff     <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_kind_ff <= req_kind;
         hold_byte_ff <= req_in_byte;
      end
   end

   // Length of the word being left is written when a space ends it; only words
   // below the current one are ever read back.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem[wi_ff] <= ci_ff;
      end
      if (rd_en) begin
         rd_data_ff <= len_mem[wi_ff - 1'b1];
      end
   end

   sled_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (emit_load),
      .burst             (burst),
      .free              (emit_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .rsp_line_done     (rsp_line_done),
      .rsp_word_count    (rsp_word_count),
      .rsp_command_class (rsp_command_class)
   );

   a_rdwait_held : assert property (@(posedge clock) disable iff (reset)
      rdwait_ff |-> hold_vld_ff && need_rd)
      else $error("memory read pending without a backspace in execute");

   a_rd_then_done : assert property (@(posedge clock) disable iff (reset)
      rd_en |=> !rd_en)
      else $error("word length read issued twice for one item");

   a_state_stable : assert property (@(posedge clock) disable iff (reset)
      !exe_done |=> $stable(wi_ff) && $stable(ci_ff))
      else $error("line state changed without a completed item");

   a_ci_bound : assert property (@(posedge clock) disable iff (reset)
      ci_ff <= CI_FULL && wi_ff <= WI_LAST)
      else $error("word or character index out of range");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      emit_load |-> emit_free)
      else $error("burst loaded while emitter busy");

endmodule
